@@ rtl/set_assoc_lru_cache_lookup_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the cache lookup block
// Shared property shorthands, sampled on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_LOOKUP_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_LOOKUP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SALC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SALC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/salc_pkg.sv @@
// ----------------------------------------------------------------------------
// salc_pkg
// Shared codes, widths and defaults of the set-associative LRU cache lookup.
// ----------------------------------------------------------------------------
package salc_pkg;

    typedef logic [1:0] action_t;
    typedef logic [1:0] outcome_t;

    // Request actions
    localparam action_t ACT_OTHER  = 2'd0;
    localparam action_t ACT_LOAD   = 2'd1;
    localparam action_t ACT_STORE  = 2'd2;
    localparam action_t ACT_MODIFY = 2'd3;

    // Lookup outcomes
    localparam outcome_t OUTC_HIT   = 2'd0;
    localparam outcome_t OUTC_FILL  = 2'd1;
    localparam outcome_t OUTC_EVICT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SET_INDEX_BITS = 2'd0;
    localparam logic [1:0] CFG_OFFSET_BITS    = 2'd1;
    localparam logic [1:0] CFG_WAYS_IN_USE    = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int SIB_W       = 3;
    localparam int OFS_W       = 6;
    localparam int WAYS_CFG_W  = 3;
    localparam int ADDR_W      = 64;
    localparam int COUNT_W     = 32;
    localparam int SHIFT_W     = 7;

    // The set field before folding onto the physical sets has at most 2^SIB_W - 1 bits.
    localparam int SET_RAW_W = 7;
    localparam int SET_RAW_N = 128;

    localparam int MAX_SETS_DEF = 64;
    localparam int MAX_WAYS_DEF = 4;

endpackage

@@ rtl/set_assoc_lru_cache_lookup.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup
// Tag-only set-associative cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//
//  Channel   | Signals                                    | Handshake
//  ----------+--------------------------------------------+-----------------------
//  request   | action, address                            | start high, busy low
//  result    | outcome, last, hit/miss/eviction_total     | done, one cycle
//  config    | cfg_index, cfg_data                        | cfg_we, no wait
//
// A load or store request does one lookup, a modify two and an other action
// none. The set memory read is registered, and each lookup is written back
// before the next read of the same set; the second lookup of a modify works
// on the forwarded row instead of a fresh read.
// Reset clears the valid bits, the counters and the time stamp at once.
// Results are registered and shown on done for one cycle; the receiver
// cannot stall them.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup #(
    parameter int MAX_SETS = salc_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  salc_pkg::action_t                  action,
    input  logic [salc_pkg::ADDR_W-1:0]        address,
    input  logic                               cfg_we,
    input  logic [salc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                               done,
    output salc_pkg::outcome_t                 outcome,
    output logic                               last,
    output logic [salc_pkg::COUNT_W-1:0]       hit_total,
    output logic [salc_pkg::COUNT_W-1:0]       miss_total,
    output logic [salc_pkg::COUNT_W-1:0]       eviction_total
);

    localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SET_MAP_W = salc_pkg::SET_RAW_N * SET_W;
    localparam int AW        = salc_pkg::ADDR_W;
    localparam int CW        = salc_pkg::COUNT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOOK  = 2'd1;
    localparam logic [1:0] ST_LOOK2 = 2'd2;

    typedef logic [MAX_WAYS-1:0][AW-1:0] tag_row_t;
    typedef logic [MAX_WAYS-1:0][CW-1:0] stamp_row_t;

    // Folds the raw set field onto the physical sets (wraps modulo MAX_SETS).
    function automatic logic [SET_MAP_W-1:0] build_set_map();
        logic [SET_MAP_W-1:0] m;
        m = '0;
        for (int i = 0; i < salc_pkg::SET_RAW_N; i++) begin
            m[i*SET_W +: SET_W] = SET_W'(i % MAX_SETS);
        end
        return m;
    endfunction

    localparam logic [SET_MAP_W-1:0] SET_MAP = build_set_map();

    // Configuration
    logic [salc_pkg::SIB_W-1:0]      set_index_bits_reg;
    logic [salc_pkg::OFS_W-1:0]      offset_bits_reg;
    logic [salc_pkg::WAYS_CFG_W-1:0] ways_in_use_reg;

    // Control and counters
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] time_reg;
    logic [CW-1:0] hit_cnt_reg, miss_cnt_reg, evict_cnt_reg;
    logic          modify_reg;
    logic [MAX_SETS-1:0][MAX_WAYS-1:0] valid_reg;

    // Request payload
    logic [SET_W-1:0] set_reg;
    logic [AW-1:0]    tag_reg;

    // Set memory and its registered read data
    tag_row_t   tag_mem   [MAX_SETS];
    stamp_row_t stamp_mem [MAX_SETS];
    tag_row_t   rd_tag_reg,  fwd_tag_reg;
    stamp_row_t rd_stamp_reg, fwd_stamp_reg;

    // Result registers
    logic                done_reg;
    logic                last_reg;
    salc_pkg::outcome_t  outcome_reg;

    logic                          accept;
    logic                          lookup_active;
    logic [AW-1:0]                 addr_shifted;
    logic [salc_pkg::SET_RAW_W-1:0] set_mask;
    logic [salc_pkg::SET_RAW_W-1:0] set_raw;
    logic [SET_W-1:0]              set_in;
    logic [salc_pkg::SHIFT_W-1:0]  tag_shift;
    logic [AW-1:0]                 tag_in;

    tag_row_t            cur_tag, new_tag;
    stamp_row_t          cur_stamp, new_stamp;
    logic [MAX_WAYS-1:0] cur_valid, in_use;
    logic                hit_found, empty_found, lru_found;
    logic [WAY_W-1:0]    hit_way, empty_way, lru_way, victim;
    logic [CW-1:0]       lru_stamp;
    salc_pkg::outcome_t  outcome_next;

    assign busy          = (state_reg != ST_IDLE);
    assign accept        = start && !busy;
    assign lookup_active = (state_reg == ST_LOOK) || (state_reg == ST_LOOK2);

    // Set index and tag of the incoming request
    assign addr_shifted = address >> offset_bits_reg;
    assign set_mask     = salc_pkg::SET_RAW_W'((8'd1 << set_index_bits_reg) - 8'd1);
    assign set_raw      = addr_shifted[salc_pkg::SET_RAW_W-1:0] & set_mask;
    assign set_in       = SET_MAP[int'(set_raw)*SET_W +: SET_W];
    assign tag_shift    = salc_pkg::SHIFT_W'(set_index_bits_reg)
                        + salc_pkg::SHIFT_W'(offset_bits_reg);
    assign tag_in       = address >> tag_shift;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            set_index_bits_reg <= '0;
            offset_bits_reg    <= '0;
            ways_in_use_reg    <= salc_pkg::WAYS_CFG_W'(1);
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                salc_pkg::CFG_SET_INDEX_BITS:
                    set_index_bits_reg <= cfg_data[salc_pkg::SIB_W-1:0];
                salc_pkg::CFG_OFFSET_BITS:
                    offset_bits_reg <= cfg_data[salc_pkg::OFS_W-1:0];
                salc_pkg::CFG_WAYS_IN_USE:
                    ways_in_use_reg <= cfg_data[salc_pkg::WAYS_CFG_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Set memory: read on accept, whole row written back after each lookup.
    always_ff @(posedge clk) begin
        if (accept) begin
            rd_tag_reg   <= tag_mem[set_in];
            rd_stamp_reg <= stamp_mem[set_in];
        end
        if (lookup_active) begin
            tag_mem[set_reg]   <= new_tag;
            stamp_mem[set_reg] <= new_stamp;
        end
    end

    // Payload and forwarded row for the second lookup of a modify
    always_ff @(posedge clk) begin
        if (accept) begin
            set_reg <= set_in;
            tag_reg <= tag_in;
        end
        if (lookup_active) begin
            fwd_tag_reg   <= new_tag;
            fwd_stamp_reg <= new_stamp;
            outcome_reg   <= outcome_next;
            last_reg      <= (state_reg == ST_LOOK2) || !modify_reg;
        end
    end

    assign cur_tag   = (state_reg == ST_LOOK2) ? fwd_tag_reg   : rd_tag_reg;
    assign cur_stamp = (state_reg == ST_LOOK2) ? fwd_stamp_reg : rd_stamp_reg;
    assign cur_valid = valid_reg[set_reg];

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            in_use[i] = (i == 0) || (int'(ways_in_use_reg) > i);
        end
    end

    // Hit search, first empty way and first way with the smallest stamp
    always_comb begin
        hit_found   = 1'b0;
        empty_found = 1'b0;
        lru_found   = 1'b0;
        hit_way     = '0;
        empty_way   = '0;
        lru_way     = '0;
        lru_stamp   = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (in_use[i]) begin
                if (cur_valid[i]) begin
                    if (!hit_found && (cur_tag[i] == tag_reg)) begin
                        hit_found = 1'b1;
                        hit_way   = WAY_W'(i);
                    end
                    if (!lru_found || (lru_stamp > cur_stamp[i])) begin
                        lru_found = 1'b1;
                        lru_way   = WAY_W'(i);
                        lru_stamp = cur_stamp[i];
                    end
                end
                else if (!empty_found) begin
                    empty_found = 1'b1;
                    empty_way   = WAY_W'(i);
                end
            end
        end
    end

    always_comb begin
        if (hit_found) begin
            victim       = hit_way;
            outcome_next = salc_pkg::OUTC_HIT;
        end
        else if (empty_found) begin
            victim       = empty_way;
            outcome_next = salc_pkg::OUTC_FILL;
        end
        else begin
            victim       = lru_way;
            outcome_next = salc_pkg::OUTC_EVICT;
        end
        new_tag           = cur_tag;
        new_stamp         = cur_stamp;
        new_tag[victim]   = tag_reg;
        new_stamp[victim] = time_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && (action != salc_pkg::ACT_OTHER)) begin
                    state_next = ST_LOOK;
                end
            ST_LOOK:
                state_next = modify_reg ? ST_LOOK2 : ST_IDLE;
            ST_LOOK2:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            time_reg      <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            modify_reg    <= 1'b0;
            valid_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            done_reg  <= lookup_active;
            if (accept) begin
                time_reg   <= time_reg + CW'(1);
                modify_reg <= (action == salc_pkg::ACT_MODIFY);
            end
            if (lookup_active) begin
                valid_reg[set_reg][victim] <= 1'b1;
                unique case (outcome_next)
                    salc_pkg::OUTC_HIT:
                        hit_cnt_reg <= hit_cnt_reg + CW'(1);
                    salc_pkg::OUTC_FILL:
                        miss_cnt_reg <= miss_cnt_reg + CW'(1);
                    salc_pkg::OUTC_EVICT:
                    begin
                        miss_cnt_reg  <= miss_cnt_reg + CW'(1);
                        evict_cnt_reg <= evict_cnt_reg + CW'(1);
                    end
                    default:
                        ;
                endcase
            end
        end
    end

    assign done           = done_reg;
    assign outcome        = outcome_reg;
    assign last           = last_reg;
    assign hit_total      = hit_cnt_reg;
    assign miss_total     = miss_cnt_reg;
    assign eviction_total = evict_cnt_reg;

endmodule

@@ rtl/salc_checker.sv @@
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks on the cache lookup block, attached by bind.
// ----------------------------------------------------------------------------
`include "set_assoc_lru_cache_lookup_macros.svh"

module salc_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  salc_pkg::action_t             action,
    input  logic                          done,
    input  logic                          last,
    input  logic [salc_pkg::COUNT_W-1:0]  hit_total,
    input  logic [salc_pkg::COUNT_W-1:0]  miss_total
);

    // The second result of a modify follows the first directly.
    `SALC_ASSERT_NEXT(a_modify_pair, done && !last, done && last, "second lookup result missing")

    // A request that does a lookup keeps the block busy for the next cycle.
    `SALC_ASSERT_NEXT(a_lookup_busy, start && !busy && (action != salc_pkg::ACT_OTHER), busy, "lookup request did not raise busy")

    // An other action gives no result in the cycle after it is taken.
    `SALC_ASSERT_NEXT(a_other_silent, start && !busy && (action == salc_pkg::ACT_OTHER), !done, "result after an other action")

    // Each result counts exactly one hit or one miss.
    `SALC_ASSERT_SAME(a_one_count, done, salc_pkg::COUNT_W'((hit_total - $past(hit_total)) + (miss_total - $past(miss_total))) == salc_pkg::COUNT_W'(1), "totals did not advance by one")

endmodule

bind set_assoc_lru_cache_lookup salc_checker u_salc_checker (.*);
